// ===== rtl/spwr_pkg.sv =====
// Package: shared types and constants of the speed PID controller.
`default_nettype none

package spwr_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_WINDUP     = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_MAX_OUTPUT = 3'd4;

  // Register values after reset.
  localparam logic [15:0] GAIN_P_RESET     = 16'd256;
  localparam logic [15:0] GAIN_I_RESET     = 16'd0;
  localparam logic [15:0] GAIN_D_RESET     = 16'd0;
  localparam logic [15:0] WINDUP_RESET     = 16'd50;
  localparam logic [15:0] MAX_OUTPUT_RESET = 16'd255;

  // Bound that the integral magnitude never exceeds.
  localparam logic signed [17:0] INTEGRAL_BOUND = 18'sd98304;

  // Word leaving the error stage.
  typedef struct packed {
    logic signed [16:0] err;
    logic signed [17:0] integ;
    logic signed [17:0] diff;
    logic [15:0]        drive;
  } spwr_err_word_t;

  // Word leaving the product stage.
  typedef struct packed {
    logic signed [32:0] prod_p;
    logic signed [33:0] prod_i;
    logic signed [33:0] prod_d;
    logic [15:0]        drive;
  } spwr_prod_word_t;

  // Gains in signed Q8.8.
  typedef struct packed {
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic signed [15:0] gain_d;
  } spwr_gains_t;

endpackage

`default_nettype wire

// ===== rtl/spwr_error_stage.sv =====
// Input register, error calculation and integral with windup reset.
`default_nettype none

module spwr_error_stage
  import spwr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire logic signed [15:0]   target_speed,
  input  wire logic signed [15:0]   measured_speed,
  input  wire logic [15:0]          present_drive,
  input  wire logic [15:0]          windup_limit,
  output logic                      err_valid,
  input  wire logic                 err_ready,
  output spwr_err_word_t            err_word
);

  logic                s1_valid;
  logic signed [15:0]  s1_target;
  logic signed [15:0]  s1_measured;
  logic [15:0]         s1_drive;
  logic                s2_ready;
  logic                s2_load;

  logic signed [17:0]  integral_sum;
  logic signed [16:0]  previous_error;
  logic signed [17:0]  integral_next;

  logic signed [16:0]  target_ext;
  logic signed [16:0]  measured_ext;
  logic signed [16:0]  target_mag;
  logic signed [16:0]  measured_mag;
  logic signed [16:0]  err;
  logic signed [17:0]  integral_mag;

  // Handshake: each register takes a new word when empty or when its word moves on.
  assign s2_ready   = !err_valid || err_ready;
  assign item_ready = !s1_valid || s2_ready;
  assign s2_load    = s1_valid && s2_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      s1_target   <= target_speed;
      s1_measured <= measured_speed;
      s1_drive    <= present_drive;
    end
  end

  // Error is the difference of the two magnitudes.
  always_comb begin
    target_ext   = {s1_target[15], s1_target};
    measured_ext = {s1_measured[15], s1_measured};
    target_mag   = s1_target[15] ? -target_ext : target_ext;
    measured_mag = s1_measured[15] ? -measured_ext : measured_ext;
    err          = target_mag - measured_mag;
  end

  // The integral accumulates while below the limit, otherwise it is cleared.
  always_comb begin
    integral_mag = integral_sum[17] ? -integral_sum : integral_sum;
    if ($unsigned(integral_mag) < {2'b00, windup_limit}) begin
      integral_next = integral_sum + 18'(err);
    end else begin
      integral_next = '0;
    end
  end

  // Controller state and the outgoing word.
  always_ff @(posedge clk) begin
    if (rst) begin
      err_valid      <= 1'b0;
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      if (s2_ready) begin
        err_valid <= s1_valid;
      end
      if (s2_load) begin
        integral_sum   <= integral_next;
        previous_error <= err;
      end
    end
    if (s2_load) begin
      err_word.err   <= err;
      err_word.integ <= integral_next;
      err_word.diff  <= 18'(previous_error) - 18'(err);
      err_word.drive <= s1_drive;
    end
  end

`ifndef SYNTH
  a_integral_bounded: assert property (@(posedge clk) disable iff (rst)
    (integral_sum <= INTEGRAL_BOUND) && (integral_sum >= -INTEGRAL_BOUND))
    else $error("integral outside its reachable range");

  a_state_moves_with_word: assert property (@(posedge clk)
    !$past(s2_load) && !$past(rst) |-> $stable(integral_sum) && $stable(previous_error))
    else $error("controller state changed without a word advancing");

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> s1_valid && err_valid)
    else $error("input stalled while a register is empty");

  a_error_in_range: assert property (@(posedge clk) disable iff (rst)
    (previous_error <= 17'sd32768) && (previous_error >= -17'sd32768))
    else $error("previous error outside its range");
`endif

endmodule

`default_nettype wire

// ===== rtl/spwr_product_stage.sv =====
// Product stage: the three gain multiplications, each registered.
`default_nettype none

module spwr_product_stage
  import spwr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            err_valid,
  output logic                 err_ready,
  input  wire spwr_err_word_t  err_word,
  input  wire spwr_gains_t     gains,
  output logic                 prod_valid,
  input  wire logic            prod_ready,
  output spwr_prod_word_t      prod_word
);

  logic prod_load;

  assign err_ready = !prod_valid || prod_ready;
  assign prod_load = err_valid && err_ready;

  // Proportional, integral and derivative products.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (err_ready) begin
      prod_valid <= err_valid;
    end
    if (prod_load) begin
      prod_word.prod_p <= 33'(err_word.err) * 33'(gains.gain_p);
      prod_word.prod_i <= 34'(err_word.integ) * 34'(gains.gain_i);
      prod_word.prod_d <= 34'(err_word.diff) * 34'(gains.gain_d);
      prod_word.drive  <= err_word.drive;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/spwr_output_stage.sv =====
// Output stage: sum, truncation toward zero, drive update and clamp.
`default_nettype none

module spwr_output_stage
  import spwr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            prod_valid,
  output logic                 prod_ready,
  input  wire spwr_prod_word_t prod_word,
  input  wire logic [15:0]     max_output,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output logic [15:0]          drive_out
);

  logic               out_load;
  logic signed [35:0] sum_q8;
  logic signed [35:0] sum_adj;
  logic signed [27:0] corr;
  logic signed [28:0] total;
  logic [15:0]        drive_clamped;

  assign prod_ready = !result_valid || result_ready;
  assign out_load   = prod_valid && prod_ready;

  // Rounding toward zero: negative sums get 255 added before the shift.
  always_comb begin
    sum_q8  = 36'(prod_word.prod_p) + 36'(prod_word.prod_i) + 36'(prod_word.prod_d);
    sum_adj = sum_q8 + {28'd0, {8{sum_q8[35]}}};
    corr    = sum_adj[35:8];
    total   = $signed({13'd0, prod_word.drive}) + {corr[27], corr};
    if (total[28]) begin
      drive_clamped = '0;
    end else if (total[27:0] > {12'd0, max_output}) begin
      drive_clamped = max_output;
    end else begin
      drive_clamped = total[15:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (prod_ready) begin
      result_valid <= prod_valid;
    end
    if (out_load) begin
      drive_out <= drive_clamped;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/speed_pid_with_windup_reset_core.sv =====
// Top level: configuration registers and the three-stage PID pipeline.
// Throughput: one word per cycle; input register, error, product and result
// registers each pass one word on every cycle the result side is ready.
// Reset empties the pipeline, clears the integral and the previous error and
// loads the gains, windup limit and maximum output with their reset values.
`default_nettype none

module speed_pid_with_windup_reset_core
  import spwr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [15:0]              cfg_data,
  input  wire logic                     item_valid,
  output logic                          item_ready,
  input  wire logic signed [15:0]       target_speed,
  input  wire logic signed [15:0]       measured_speed,
  input  wire logic [15:0]              present_drive,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output logic [15:0]                   drive_out
);

  spwr_gains_t     gains;
  logic [15:0]     windup_limit;
  logic [15:0]     max_output;

  logic            err_valid;
  logic            err_ready;
  spwr_err_word_t  err_word;
  logic            prod_valid;
  logic            prod_ready;
  spwr_prod_word_t prod_word;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.gain_p <= GAIN_P_RESET;
      gains.gain_i <= GAIN_I_RESET;
      gains.gain_d <= GAIN_D_RESET;
      windup_limit <= WINDUP_RESET;
      max_output   <= MAX_OUTPUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_P:     gains.gain_p <= cfg_data;
        REG_GAIN_I:     gains.gain_i <= cfg_data;
        REG_GAIN_D:     gains.gain_d <= cfg_data;
        REG_WINDUP:     windup_limit <= cfg_data;
        REG_MAX_OUTPUT: max_output   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  spwr_error_stage u_error (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .target_speed   (target_speed),
    .measured_speed (measured_speed),
    .present_drive  (present_drive),
    .windup_limit   (windup_limit),
    .err_valid      (err_valid),
    .err_ready      (err_ready),
    .err_word       (err_word)
  );

  spwr_product_stage u_product (
    .clk        (clk),
    .rst        (rst),
    .err_valid  (err_valid),
    .err_ready  (err_ready),
    .err_word   (err_word),
    .gains      (gains),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod_word  (prod_word)
  );

  spwr_output_stage u_output (
    .clk          (clk),
    .rst          (rst),
    .prod_valid   (prod_valid),
    .prod_ready   (prod_ready),
    .prod_word    (prod_word),
    .max_output   (max_output),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .drive_out    (drive_out)
  );

endmodule

`default_nettype wire

// ===== test/speed_pid_with_windup_reset_core_tb.sv =====
// Self-checking testbench for the speed PID controller with integral windup reset.
`default_nettype none

module speed_pid_with_windup_reset_core_tb;
  import spwr_pkg::*;

  // One speed sample as offered on the input channel.
  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] measured;
    logic [15:0]        drive;
  } speed_sample_t;

  localparam logic [CfgIndexWidth-1:0] REG_FIRST_UNUSED = REG_MAX_OUTPUT + 1'b1;
  localparam int unsigned LONG_HOLD_CYCLES = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  logic signed [15:0] target_speed = '0;
  logic signed [15:0] measured_speed = '0;
  logic [15:0] present_drive = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [15:0] drive_out;

  // Controller settings as the block should hold them.
  logic signed [15:0] p_gain = GAIN_P_RESET;
  logic signed [15:0] i_gain = GAIN_I_RESET;
  logic signed [15:0] d_gain = GAIN_D_RESET;
  logic [15:0] windup_cfg = WINDUP_RESET;
  logic [15:0] drive_ceiling = MAX_OUTPUT_RESET;

  // Controller state as the block should hold it.
  logic signed [17:0] integ_acc;
  logic signed [16:0] prev_err;

  speed_sample_t pending_samples[$];
  logic [15:0] expected_drive[$];
  int unsigned fault_count = 0;
  int unsigned send_gap_max = 0;
  int unsigned recv_gap_max = 0;
  int unsigned hold_token = 0;

  speed_pid_with_windup_reset_core i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .target_speed(target_speed),
    .measured_speed(measured_speed),
    .present_drive(present_drive),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .drive_out(drive_out)
  );

  always #6 clk = ~clk;

  // Works out the new drive value for one sample and advances the controller state.
  function automatic logic [15:0] next_drive(speed_sample_t s);
    longint tgt, meas, err, integ, sum_q8, total;
    tgt = longint'($signed(s.target));
    meas = longint'($signed(s.measured));
    if (tgt < 0) tgt = -tgt;
    if (meas < 0) meas = -meas;
    err = tgt - meas;
    integ = longint'(integ_acc);
    // The integral only grows while its magnitude is under the limit.
    if ((integ < 0 ? -integ : integ) < longint'(windup_cfg)) begin
      integ = integ + err;
    end else begin
      integ = 0;
    end
    integ_acc = integ[17:0];
    sum_q8 = err * longint'(p_gain) + integ * longint'(i_gain)
           + (longint'(prev_err) - err) * longint'(d_gain);
    prev_err = err[16:0];
    // Division of a signed longint truncates toward zero.
    total = longint'(s.drive) + sum_q8 / 256;
    if (total < 0) total = 0;
    if (total > longint'(drive_ceiling)) total = longint'(drive_ceiling);
    return total[15:0];
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3, 4, 5: return 16'($urandom_range(0, 1024)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom_range(1, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  // Writes one register and keeps the local copy of the settings in step.
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_GAIN_P: p_gain = value;
      REG_GAIN_I: i_gain = value;
      REG_GAIN_D: d_gain = value;
      REG_WINDUP: windup_cfg = value;
      REG_MAX_OUTPUT: drive_ceiling = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_sample(input logic [15:0] tgt, input logic [15:0] meas,
                              input logic [15:0] drv);
    pending_samples.push_back(speed_sample_t'{tgt, meas, drv});
  endtask

  // Random samples: mostly small or near-equal speeds so the integral builds up and
  // crosses the windup limit, with some fully random words mixed in.
  task automatic queue_random_samples(input int unsigned count);
    speed_sample_t s;
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(0, 3))
        0: begin
          s.target = 16'($urandom);
          s.measured = 16'($urandom);
        end
        1: begin
          s.target = 16'($urandom);
          s.measured = s.target + 16'($urandom_range(0, 64)) - 16'd32;
          if ($urandom_range(0, 1)) s.measured = -s.measured;
        end
        default: begin
          s.target = 16'($urandom_range(0, 600)) - 16'd300;
          s.measured = 16'($urandom_range(0, 600)) - 16'd300;
        end
      endcase
      s.drive = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3000));
      pending_samples.push_back(s);
    end
  endtask

  // Waits until every queued word has gone in and every result has come out.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || item_valid || expected_drive.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Input side: offers queued words, with a random pause after each one.
  always @(posedge clk) begin : sample_feed
    int unsigned gap_left;
    speed_sample_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
      gap_left = 0;
    end else if (!item_valid || item_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        nxt = pending_samples.pop_front();
        item_valid <= 1'b1;
        target_speed <= nxt.target;
        measured_speed <= nxt.measured;
        present_drive <= nxt.drive;
        gap_left = $urandom_range(0, send_gap_max);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Output side: predicts on each accepted word, checks each result and stalls at random.
  always @(posedge clk) begin : drive_check
    logic [15:0] want;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned hold_seen;
    if (rst) begin
      result_ready <= 1'b0;
      integ_acc = '0;
      prev_err = '0;
      stall_left = 0;
      hold_left = 0;
      hold_seen = hold_token;
    end else begin
      if (item_valid && item_ready) begin
        expected_drive.push_back(next_drive(speed_sample_t'{target_speed, measured_speed,
                                                            present_drive}));
      end
      if (result_valid && result_ready) begin
        if (expected_drive.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected drive_out %0d, expected none", $time, drive_out);
        end else begin
          want = expected_drive.pop_front();
          if (drive_out !== want) begin
            fault_count++;
            $display("%0t: drive_out mismatch, expected %0d, actual %0d",
                     $time, want, drive_out);
          end
        end
        stall_left = $urandom_range(0, recv_gap_max);
      end
      // A long hold lets the pipeline fill and push back on the input.
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed samples first, then random phases under varied settings.
  initial begin
    int unsigned phase;
    int unsigned idx;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Settings after reset: extremes of speed, negative total and upper clamp.
    queue_sample(16'sd0, 16'sd0, 16'd0);
    queue_sample(16'h8000, 16'sd0, 16'd0);
    queue_sample(16'sd0, 16'h8000, 16'd200);
    queue_sample(16'sd32767, -16'sd32767, 16'hffff);
    queue_sample(-16'sd100, 16'sd40, 16'd10);
    queue_sample(16'sd5, -16'sd5, 16'hffff);
    wait_drained();

    // Extreme gains and limits; the integral climbs close to its bound, then clears.
    write_reg(REG_GAIN_P, 16'h8000);
    write_reg(REG_GAIN_I, 16'h7fff);
    write_reg(REG_GAIN_D, 16'h8000);
    write_reg(REG_WINDUP, 16'hffff);
    write_reg(REG_MAX_OUTPUT, 16'hffff);
    queue_sample(16'sd32767, 16'sd0, 16'd32768);
    queue_sample(16'sd32767, 16'sd0, 16'hffff);
    queue_sample(16'h8000, 16'sd0, 16'd0);
    queue_sample(16'sd1, 16'sd0, 16'd1);
    queue_sample(16'sd0, 16'h8000, 16'hffff);
    queue_sample(16'h8000, 16'h8000, 16'd12345);
    queue_sample(-16'sd1, 16'sd32767, 16'd40000);
    wait_drained();

    // Zero windup limit and zero ceiling; writes to unused indexes must change nothing.
    write_reg(REG_WINDUP, 16'h0000);
    write_reg(REG_MAX_OUTPUT, 16'h0000);
    for (idx = 32'(REG_FIRST_UNUSED); idx < 2 ** CfgIndexWidth; idx++) begin
      write_reg(CfgIndexWidth'(idx), 16'($urandom));
    end
    queue_sample(16'sd300, 16'sd10, 16'hffff);
    queue_sample(16'h8000, 16'sd0, 16'd500);
    queue_sample(16'sd7, -16'sd9, 16'd0);
    queue_sample(16'sd0, 16'sd0, 16'hffff);
    wait_drained();

    // Random phases, each with fresh settings and its own idling pattern.
    for (phase = 0; phase < 6; phase++) begin
      write_reg(REG_GAIN_P, pick_gain());
      write_reg(REG_GAIN_I, pick_gain());
      write_reg(REG_GAIN_D, pick_gain());
      write_reg(REG_WINDUP, pick_limit());
      write_reg(REG_MAX_OUTPUT, pick_limit());
      case (phase % 4)
        0: begin send_gap_max <= 7; recv_gap_max <= 7; end
        1: begin send_gap_max <= 0; recv_gap_max <= 0; end
        2: begin send_gap_max <= 7; recv_gap_max <= 0; end
        default: begin send_gap_max <= 0; recv_gap_max <= 7; end
      endcase
      if (phase == 1) begin
        // Back-pressure: hold the result side while words keep coming, then pause
        // the input side until everything has come back.
        queue_random_samples(70);
        hold_token <= hold_token + 1;
        wait_drained();
        queue_random_samples(70);
      end else begin
        queue_random_samples(140);
      end
      wait_drained();
    end

    repeat (6) @(posedge clk);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog in case the block hangs.
  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
